// File: rtl/fed_pkg.sv
// ============================================================================
// fed_pkg
// Shared types and constants of the feedback echo delay core.
// ============================================================================
package fed_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 17;

    localparam int RING_DEPTH_DEF = 65536;
    localparam int CHANNELS_DEF   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIX      = 2'd2;

    localparam logic [15:0] DELAY_RST    = 16'd15360;
    localparam logic [15:0] FEEDBACK_RST = 16'd22938;
    localparam logic [16:0] MIX_RST      = 17'd13107;

    typedef struct packed {
        logic                       channel;
        logic signed [SAMPLE_W-1:0] sample_in;
    } in_beat_t;

    typedef struct packed {
        logic                       channel_out;
        logic signed [SAMPLE_W-1:0] sample_out;
    } out_beat_t;

endpackage

// File: rtl/feedback_echo_delay_core.sv
// ============================================================================
// feedback_echo_delay_core
// Per-channel feedback echo: ring read, gain, write-back and wet/dry blend.
// ============================================================================
// Path: ring read and multiply stage, write-back stage, then output register.
// Throughput: one beat per cycle unless the output stalls; input stalls while a read
// hits the entry of a same-channel beat not yet written back (one-write delay).
// Reset: clears write positions and fill counts at once; no clearing pass,
// ring entries beyond the fill count read as zero. Registers take defaults.
module feedback_echo_delay_core
    import fed_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int CHANNELS   = CHANNELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_beat_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_beat_t             out_data,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int CW    = $clog2(RING_DEPTH + 1);
    localparam int XW    = (CW > 16) ? CW : 16;
    localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MDEP  = CHANNELS * RING_DEPTH;
    localparam int MAW   = $clog2(MDEP);

    logic [15:0]          delay_reg;
    logic [15:0]          feedback_reg;
    logic [16:0]          mix_reg;

    logic [AW-1:0]        wp_reg   [CHANNELS];
    logic [CW-1:0]        fill_reg [CHANNELS];

    logic [15:0]          ring_mem [MDEP];
    logic [15:0]          rd_data_reg;

    logic                 v1_reg;
    logic                 v1_next;
    logic signed [15:0]   s1_x_reg;
    logic                 s1_ch_reg;
    logic [MAW-1:0]       s1_wr_addr_reg;
    logic [MAW-1:0]       s1_rd_addr_reg;
    logic                 s1_hit_reg;
    logic                 s1_fwd_reg;
    logic [15:0]          s1_fwd_val_reg;

    logic                 v2_reg;
    logic                 v2_next;
    logic [MAW-1:0]       s2_addr_reg;
    logic                 s2_ch_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_beat_t            out_data_reg;

    logic [CHW-1:0]       ch;
    logic [AW-1:0]        wp;
    logic [CW-1:0]        fill;
    logic [XW-1:0]        d_x;
    logic [XW-1:0]        d_eff;
    logic [AW-1:0]        dm;
    logic [AW:0]          rp_wrap;
    logic [AW-1:0]        rp;
    logic                 rd_hit;
    logic [MAW-1:0]       rd_addr;
    logic [MAW-1:0]       wr_addr;
    logic [AW-1:0]        wp_next;
    logic [CW-1:0]        fill_next;

    logic                 adv_out;
    logic                 adv2;
    logic                 adv1;
    logic                 acc;
    logic                 we;
    logic                 match1;
    logic                 match2;
    logic                 fwd_next;

    logic signed [15:0]   delayed;
    logic signed [15:0]   written;
    logic signed [15:0]   mixed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= DELAY_RST;
            feedback_reg <= FEEDBACK_RST;
            mix_reg      <= MIX_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DELAY:    delay_reg    <= cfg_data[15:0];
                REG_FEEDBACK: feedback_reg <= cfg_data[15:0];
                REG_MIX:      mix_reg      <= cfg_data[16:0];
                default:      ;
            endcase
        end
    end

    // read address and fill check for the incoming beat
    always_comb
    begin
        ch      = (int'(in_data.channel) < CHANNELS) ? CHW'(in_data.channel)
                                                     : CHW'(CHANNELS - 1);
        wp      = wp_reg[ch];
        fill    = fill_reg[ch];
        d_x     = XW'(delay_reg);
        d_eff   = ((d_x == '0) || (d_x > XW'(RING_DEPTH))) ? XW'(RING_DEPTH) : d_x;
        rd_hit  = (XW'(fill) >= d_eff);
        dm      = (d_eff == XW'(RING_DEPTH)) ? '0 : AW'(d_eff);
        rp_wrap = {1'b0, wp} + (AW+1)'(RING_DEPTH) - {1'b0, dm};
        rp      = (wp >= dm) ? (wp - dm) : rp_wrap[AW-1:0];
        rd_addr = MAW'(ch) * MAW'(RING_DEPTH) + MAW'(rp);
        wr_addr = MAW'(ch) * MAW'(RING_DEPTH) + MAW'(wp);
        wp_next   = (wp == AW'(RING_DEPTH - 1)) ? '0 : wp + AW'(1);
        fill_next = (fill == CW'(RING_DEPTH)) ? fill : fill + CW'(1);
    end

    // pipeline flow and hazard interlock
    always_comb
    begin
        adv_out  = !out_valid_reg || out_ready;
        adv2     = !v2_reg || adv_out;
        adv1     = !v1_reg || adv2;
        we       = v2_reg && adv_out;
        match1   = v1_reg && (s1_wr_addr_reg == rd_addr);
        match2   = v2_reg && (s2_addr_reg == rd_addr) && !we;
        in_ready = adv1 && !match1 && !match2;
        acc      = in_valid && in_ready;
        fwd_next = we && (s2_addr_reg == rd_addr);
        v1_next        = adv1 ? acc : v1_reg;
        v2_next        = adv2 ? v1_reg : v2_reg;
        out_valid_next = adv_out ? v2_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                wp_reg[i]   <= '0;
                fill_reg[i] <= '0;
            end
        end
        else if (acc)
        begin
            wp_reg[ch]   <= wp_next;
            fill_reg[ch] <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ring_mem[s2_addr_reg] <= written;
        end
        if (acc)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_x_reg       <= in_data.sample_in;
            s1_ch_reg      <= in_data.channel;
            s1_wr_addr_reg <= wr_addr;
            s1_rd_addr_reg <= rd_addr;
            s1_hit_reg     <= rd_hit;
            s1_fwd_reg     <= fwd_next;
            s1_fwd_val_reg <= written;
        end
        if (adv2)
        begin
            s2_addr_reg <= s1_wr_addr_reg;
            s2_ch_reg   <= s1_ch_reg;
        end
        if (adv_out && v2_reg)
        begin
            out_data_reg.channel_out <= s2_ch_reg;
            out_data_reg.sample_out  <= mixed;
        end
    end

    always_comb
    begin
        if (s1_fwd_reg)
        begin
            delayed = s1_fwd_val_reg;
        end
        else if (s1_hit_reg)
        begin
            delayed = rd_data_reg;
        end
        else
        begin
            delayed = '0;
        end
    end

    fed_arith u_arith (
        .clk           (clk),
        .load          (adv2 && v1_reg),
        .delayed       (delayed),
        .dry           (s1_x_reg),
        .feedback_gain (feedback_reg),
        .mix_gain      (mix_reg),
        .written       (written),
        .mixed         (mixed)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> v1_reg)
        else $error("accepted beat missing from read stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && !adv_out) |=> (v2_reg && $stable(s2_addr_reg)))
        else $error("write-back stage lost its beat under stall");

    a_fwd_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && s1_fwd_reg) |-> s1_hit_reg)
        else $error("forwarded entry outside fill range");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg) |-> (s1_rd_addr_reg != s2_addr_reg))
        else $error("read overlaps an unwritten entry in flight");

endmodule

// File: rtl/fed_arith.sv
// ============================================================================
// fed_arith
// Two-stage gain datapath: registered feedback and mix products, then
// rounding and saturation of the ring write value and the output sample.
// ============================================================================
module fed_arith
    import fed_pkg::*;
(
    input  logic                       clk,
    input  logic                       load,
    input  logic signed [SAMPLE_W-1:0] delayed,
    input  logic signed [SAMPLE_W-1:0] dry,
    input  logic        [15:0]         feedback_gain,
    input  logic        [16:0]         mix_gain,
    output logic signed [SAMPLE_W-1:0] written,
    output logic signed [SAMPLE_W-1:0] mixed
);

    logic signed [32:0] fb_prod_reg;
    logic signed [32:0] fb_prod_next;
    logic signed [34:0] mix_prod_reg;
    logic signed [34:0] mix_prod_next;
    logic signed [15:0] dry_reg;
    logic signed [16:0] diff;
    logic        [16:0] mix_c;
    logic signed [32:0] fb_biased;
    logic signed [34:0] mix_biased;
    logic signed [17:0] w_sum;
    logic signed [19:0] y_sum;

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        if (v > 20'sd32767)
        begin
            return 16'sh7fff;
        end
        if (v < -20'sd32768)
        begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    always_comb
    begin
        diff          = $signed({delayed[15], delayed}) - $signed({dry[15], dry});
        mix_c         = (mix_gain > 17'h10000) ? 17'h10000 : mix_gain;
        fb_prod_next  = 33'(delayed) * 33'($signed({1'b0, feedback_gain}));
        mix_prod_next = 35'(diff) * 35'($signed({1'b0, mix_c}));
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fb_prod_reg  <= fb_prod_next;
            mix_prod_reg <= mix_prod_next;
            dry_reg      <= dry;
        end
    end

    always_comb
    begin
        fb_biased  = fb_prod_reg + 33'sd32768;
        mix_biased = mix_prod_reg + 35'sd32768;
        w_sum      = $signed({fb_biased[32], fb_biased[32:16]})
                   + $signed({{2{dry_reg[15]}}, dry_reg});
        y_sum      = $signed({mix_biased[34], mix_biased[34:16]})
                   + $signed({{4{dry_reg[15]}}, dry_reg});
        written    = sat16($signed({{2{w_sum[17]}}, w_sum}));
        mixed      = sat16(y_sum);
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Feedback echo delay core: beats on both channels are checked against an
// in-bench echo predictor with its own rings, write positions and register
// copies. Covers reset defaults, unit and zero delay, saturating feedback and
// mix, random register settings, a long output stall and a gapless stream.
// ============================================================================
module testbench;
    import fed_pkg::*;

    localparam int LONG_HOLD = 300;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_beat_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_beat_t             out_data;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic signed [15:0] echo_hist [CHANNELS_DEF][RING_DEPTH_DEF];
    logic [15:0]        hist_wp [CHANNELS_DEF];
    logic [15:0]        cfg_delay;
    logic [15:0]        cfg_feedback;
    logic [16:0]        cfg_mix;

    out_beat_t echo_expected [$];
    out_beat_t echo_next;

    int  failures        = 0;
    int  beats_sent      = 0;
    int  results_checked = 0;
    int  settings_used   = 0;
    bit  steady_flow     = 1'b0;
    bit  source_gapless  = 1'b0;
    bit  hold_sink_request = 1'b0;

    feedback_echo_delay_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint round_q16(longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767)
            return 16'h7FFF;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    function automatic out_beat_t echo_predict(in_beat_t beat);
        int unsigned        lane;
        logic [15:0]        rd_pos;
        longint             dry;
        longint             delayed;
        longint             fb_gain;
        longint             mix_gain;
        logic signed [15:0] fed;
        out_beat_t          res;
        lane     = (beat.channel < CHANNELS_DEF) ? int'(beat.channel) : CHANNELS_DEF - 1;
        dry      = longint'(beat.sample_in);
        rd_pos   = hist_wp[lane] - cfg_delay;
        delayed  = longint'(echo_hist[lane][rd_pos]);
        fb_gain  = longint'(cfg_feedback);
        mix_gain = (cfg_mix > 17'd65536) ? 64'sd65536 : longint'(cfg_mix);
        fed      = sat16(dry + round_q16(delayed * fb_gain));
        echo_hist[lane][hist_wp[lane]] = fed;
        hist_wp[lane] = hist_wp[lane] + 16'd1;
        res.channel_out = beat.channel;
        res.sample_out  = sat16(dry + round_q16((delayed - dry) * mix_gain));
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_flow)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [15:0] pick_sample();
        int          r;
        int          v;
        logic [31:0] u;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 16'h7FFF;
        if (r < 12)
            return 16'h8000;
        if (r < 15)
            return 16'h0000;
        if (r < 18)
            return 16'hFFFF;
        if (r < 50)
        begin
            v = $urandom_range(0, 4000);
            v = v - 2000;
            return v[15:0];
        end
        u = $urandom;
        return u[15:0];
    endfunction

    // check each result beat, then record the expectation of each input beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (echo_expected.size() == 0)
                begin
                    if (failures < 10)
                        $display("%0t: unexpected result beat ch %0d sample %0d", $realtime,
                                 out_data.channel_out, $signed(out_data.sample_out));
                    failures++;
                end
                else
                begin
                    echo_next = echo_expected.pop_front();
                    if (out_data.channel_out !== echo_next.channel_out ||
                        out_data.sample_out !== echo_next.sample_out)
                    begin
                        if (failures < 10)
                            $display("%0t: result %0d expected %0d/%0d, got %0d/%0d",
                                     $realtime, results_checked, echo_next.channel_out,
                                     $signed(echo_next.sample_out), out_data.channel_out,
                                     $signed(out_data.sample_out));
                        failures++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                beats_sent++;
                echo_expected.insert(echo_expected.size(), echo_predict(in_data));
            end
        end
    end

    initial
    begin : sink
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        out_ready  = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_sink_request)
            begin
                hold_sink_request = 1'b0;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && run_left == 0)
            begin
                stall_left = pick_gap();
                run_left   = $urandom_range(1, 24);
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (run_left > 0)
                    run_left--;
            end
        end
    end

    task automatic send_beat(input logic ch, input logic signed [15:0] s);
        int gap;
        gap = source_gapless ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_data.channel   <= ch;
        in_data.sample_in <= s;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // drop valid and hold until every expected beat has come back
    task automatic settle_echo();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (echo_expected.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_echo(input logic [15:0] delay, input logic [15:0] fb,
                            input logic [16:0] mix);
        logic spare;
        spare = 1'($urandom_range(0, 1));
        cfg_write <= 1'b1;
        cfg_index <= REG_DELAY;
        cfg_data  <= {spare, delay};
        @(posedge clk);
        spare = 1'($urandom_range(0, 1));
        cfg_index <= REG_FEEDBACK;
        cfg_data  <= {spare, fb};
        @(posedge clk);
        cfg_index <= REG_MIX;
        cfg_data  <= mix;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_delay    = delay;
        cfg_feedback = fb;
        cfg_mix      = mix;
        settings_used++;
    endtask

    task automatic test_reset_state();
        send_beat(1'b0, 16'h7FFF);
        send_beat(1'b1, 16'h8000);
        send_beat(1'b0, 16'h0000);
        send_beat(1'b1, 16'hFFFF);
        send_beat(1'b0, 16'h8000);
        send_beat(1'b1, 16'h7FFF);
        settle_echo();
    endtask

    task automatic test_feedback_saturation();
        set_echo(16'd1, 16'hFFFF, 17'd65536);
        repeat (3) send_beat(1'b0, 16'h7FFF);
        repeat (3) send_beat(1'b1, 16'h8000);
        settle_echo();
        set_echo(16'd2, 16'd62259, 17'h1FFFF);
        send_beat(1'b0, 16'h8000);
        send_beat(1'b1, 16'h7FFF);
        send_beat(1'b0, 16'h1234);
        send_beat(1'b1, 16'hEDCB);
        settle_echo();
    endtask

    task automatic test_zero_delay();
        set_echo(16'd0, 16'd0, 17'd0);
        send_beat(1'b0, 16'h7FFF);
        send_beat(1'b1, 16'h8000);
        send_beat(1'b0, 16'h5555);
        settle_echo();
        set_echo(16'd0, 16'd40000, 17'd65536);
        send_beat(1'b1, 16'hAAAA);
        send_beat(1'b0, 16'h0001);
        send_beat(1'b1, 16'h7FFF);
        settle_echo();
    endtask

    task automatic test_random_echo(input int phases, input int beats);
        int          r;
        int          lane_mode;
        logic [15:0] delay;
        logic [15:0] fb;
        logic [16:0] mix;
        logic        ch;
        for (int p = 0; p < phases; p++)
        begin
            r = $urandom_range(0, 9);
            if (r == 0)
                delay = 16'd0;
            else if (r == 1)
                delay = 16'hFFFF;
            else if (r == 2)
                delay = 16'($urandom);
            else if (r < 6)
                delay = 16'($urandom_range(1, 8));
            else
                delay = 16'($urandom_range(1, 200));
            r = $urandom_range(0, 7);
            if (r == 0)
                fb = 16'd0;
            else if (r == 1)
                fb = 16'hFFFF;
            else if (r == 2)
                fb = 16'd62259;
            else
                fb = 16'($urandom);
            r = $urandom_range(0, 9);
            if (r == 0)
                mix = 17'd0;
            else if (r == 1)
                mix = 17'd65536;
            else if (r == 2)
                mix = 17'h1FFFF;
            else if (r == 3)
                mix = 17'($urandom_range(65537, 131071));
            else
                mix = 17'($urandom_range(0, 65536));
            set_echo(delay, fb, mix);
            lane_mode = $urandom_range(0, 4);
            for (int i = 0; i < beats; i++)
            begin
                ch = (lane_mode < 2) ? lane_mode[0] : 1'($urandom_range(0, 1));
                send_beat(ch, pick_sample());
                if (i == beats / 2 && $urandom_range(0, 2) == 0)
                    settle_echo();
            end
            settle_echo();
        end
    endtask

    task automatic test_output_stall();
        set_echo(16'd3, 16'd50000, 17'd40000);
        hold_sink_request = 1'b1;
        source_gapless    = 1'b1;
        for (int i = 0; i < 60; i++)
            send_beat(1'($urandom_range(0, 1)), pick_sample());
        source_gapless = 1'b0;
        settle_echo();
    endtask

    task automatic test_steady_stream();
        steady_flow = 1'b1;
        set_echo(16'd1, 16'd30000, 17'd50000);
        for (int i = 0; i < 80; i++)
            send_beat(1'($urandom_range(0, 1)), pick_sample());
        settle_echo();
        steady_flow = 1'b0;
    endtask

    initial
    begin : regression
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_write = 1'b0;
        cfg_index = REG_DELAY;
        cfg_data  = '0;
        foreach (echo_hist[c, i])
            echo_hist[c][i] = '0;
        foreach (hist_wp[c])
            hist_wp[c] = '0;
        cfg_delay    = DELAY_RST;
        cfg_feedback = FEEDBACK_RST;
        cfg_mix      = MIX_RST;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_feedback_saturation();
        test_zero_delay();
        test_random_echo(7, 85);
        test_output_stall();
        test_steady_stream();
        repeat (10) @(posedge clk);
        failures += echo_expected.size();
        $display("Echo run: %0d beats in, %0d results checked, %0d register settings",
                 beats_sent, results_checked, settings_used);
        $display("Covered reset defaults, zero and unit delay, saturation, long output stall");
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/fed_pkg.sv
rtl/fed_arith.sv
rtl/feedback_echo_delay_core.sv
test/testbench.sv
